>>> rtl/core/least_squares_linear_fit_defines.svh
// Assertion macros for the least squares fit block.
// Each use expects signals named clk and rst_n in scope.
`ifndef LEAST_SQUARES_LINEAR_FIT_DEFINES_SVH
`define LEAST_SQUARES_LINEAR_FIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LSLF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lslf assertion failed");
`define LSLF_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define LSLF_ASSERT(lbl, prop)
`define LSLF_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

>>> rtl/core/lslf_pkg.sv
package lslf_pkg;

    localparam int NUM_TERMS  = 4;
    localparam int GRAM_DEPTH = NUM_TERMS * (NUM_TERMS + 1) / 2;
    localparam int WM_DEPTH   = 32;

    localparam logic [63:0] WMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q32_ONE    = 64'h0000_0001_0000_0000;
    localparam logic signed [63:0] LOAD_LIM = 64'sd140737488355327;

    localparam logic [2:0]  TERMS_RESET     = 3'd4;
    localparam logic [15:0] MIN_PIVOT_RESET = 16'd1;

    // register indexes (paddr[2])
    localparam logic REG_TERMS_USED = 1'b0;
    localparam logic REG_MIN_PIVOT  = 1'b1;

    localparam logic [6:0] DIV_LAST_STEP = 7'd95;

    typedef struct packed {
        logic signed [15:0] term_0;
        logic signed [15:0] term_1;
        logic signed [15:0] term_2;
        logic signed [15:0] term_3;
        logic signed [15:0] target;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic [1:0]         coef_index;
        logic signed [31:0] coef_value;
        logic               coef_last;
        logic               singular;
    } coef_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DRAIN,
        S_LOAD,
        S_PV_RD,
        S_PV_CMP,
        S_PV_CHK,
        S_SW_RD,
        S_SW_W1,
        S_SW_W2,
        S_P_RD,
        S_P_LD,
        S_DV_RD,
        S_DV_GO,
        S_DV_WT,
        S_DV_ONE,
        S_F_RD,
        S_F_LD,
        S_EL_RD,
        S_EL_GO,
        S_EL_WT,
        S_EL_ZERO,
        S_O_RD,
        S_O_EM,
        S_SING,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        WR_LOAD,
        WR_RD0,
        WR_RD1,
        WR_DIV,
        WR_SUB,
        WR_ONE,
        WR_ZERO
    } wsel_t;

    typedef struct packed {
        logic       accum;
        logic       clear_sums;
        logic [1:0] row;
        logic [2:0] col;
        logic       load_cross;
        logic       rd0_en;
        logic [4:0] rd0_addr;
        logic       rd1_en;
        logic [4:0] rd1_addr;
        logic       wr_en;
        logic [4:0] wr_addr;
        wsel_t      wr_sel;
        logic       pv_clr;
        logic       pv_upd;
        logic       p_ld;
        logic       f_ld;
        logic       div_go;
        logic       mul_go;
        logic       emit;
        logic       emit_last;
        logic       emit_sing;
    } cmd_t;

    typedef struct packed {
        logic       pv_ok;
        logic [1:0] pv_row;
        logic       div_done;
        logic       mul_done;
    } status_t;

    // packed lower triangle index of (i,j)
    function automatic logic [3:0] gram_idx(input logic [1:0] i, input logic [1:0] j);
        logic [1:0] hi;
        logic [1:0] lo;
        logic [3:0] base;
        hi = (i > j) ? i : j;
        lo = (i > j) ? j : i;
        case (hi)
            2'd0: base = 4'd0;
            2'd1: base = 4'd1;
            2'd2: base = 4'd3;
            2'd3: base = 4'd6;
            default: base = 4'd0;
        endcase
        return base + {2'b00, lo};
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Q16.16 sum to Q32.32, saturated
    function automatic logic [63:0] to_q32(input logic [63:0] u);
        logic signed [63:0] s;
        s = u;
        if (s > LOAD_LIM)
            return WMAX;
        else if (s < -LOAD_LIM)
            return ~WMAX + 64'd1;
        else
            return {u[47:0], 16'h0000};
    endfunction

    function automatic logic [31:0] to_q16(input logic [63:0] w);
        logic [63:0] m;
        m = mag64(w) >> 16;
        if (w[63]) begin
            if (m > 64'h8000_0000)
                m = 64'h8000_0000;
            return ~m[31:0] + 32'd1;
        end
        if (m > 64'h7FFF_FFFF)
            m = 64'h7FFF_FFFF;
        return m[31:0];
    endfunction

    function automatic logic [63:0] qsub(input logic [63:0] a, input logic [63:0] b);
        logic signed [64:0] d;
        d = $signed({a[63], a}) - $signed({b[63], b});
        if (d > $signed({1'b0, WMAX}))
            return WMAX;
        else if (d < -$signed({1'b0, WMAX}))
            return ~WMAX + 64'd1;
        else
            return d[63:0];
    endfunction

endpackage

>>> rtl/core/least_squares_linear_fit.sv
// Least-squares linear fit. Samples (up to four Q8.8 regressors and a Q8.8
// target) are taken one per clock while busy is low; each accepted item adds
// its products into the Gram matrix X'X and the vector X'y (64-bit sums).
// The item marked last_sample starts the solve: busy rises the next cycle and
// stays high until the sums are cleared again. The solve runs Gauss-Jordan
// elimination with partial pivoting on a small work memory, then puts out one
// Q16.16 coefficient per term in use, or a single item flagged singular when
// a pivot is below min_pivot. Results are strobed for exactly one cycle on
// result_strobe and cannot be held off, so the receiver must take every one.
// Solve time is set by the bit-serial divider (n(n+1)/2 divisions) and the
// shared multiplier (roughly n^3/2 multiply-subtracts). No clearing pass is
// needed after reset.
module least_squares_linear_fit (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // sample items
    input  logic              start,
    output logic              busy,
    input  lslf_pkg::sample_t sample,
    // coefficient items
    output logic              result_strobe,
    output lslf_pkg::coef_t   result
);
    import lslf_pkg::*;

    logic [2:0]  terms_used_reg;
    logic [15:0] min_pivot_reg;
    logic        cfg_wr;
    cmd_t        cmd;
    status_t     status;

    // register file: terms_used at 0x0, min_pivot at 0x4
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            terms_used_reg <= TERMS_RESET;
            min_pivot_reg  <= MIN_PIVOT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TERMS_USED)
                terms_used_reg <= pwdata[2:0];
            else
                min_pivot_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_MIN_PIVOT) ? {16'd0, min_pivot_reg}
                                                : {29'd0, terms_used_reg};

    // sequencer
    lslf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_sample (sample.last_sample),
        .terms_used  (terms_used_reg),
        .status      (status),
        .busy        (busy),
        .cmd         (cmd)
    );

    // accumulators, work matrix, divider, multiplier, output register
    lslf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample),
        .cmd           (cmd),
        .min_pivot     (min_pivot_reg),
        .status        (status),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

>>> rtl/core/lslf_mul.sv
// Q32.32 saturating multiply, one 32x32 partial product per cycle.
module lslf_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] res
);
    import lslf_pkg::*;

    logic [2:0]  step_reg, step_next;
    logic [63:0] ua_reg, ub_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic [96:0] acc_reg, acc_next;
    logic [31:0] ah, bh;
    logic [63:0] mult;
    logic [96:0] addend;
    logic [62:0] m;

    always_comb
    begin
        case (step_reg)
            3'd1:    begin ah = ua_reg[31:0];  bh = ub_reg[31:0];  end
            3'd2:    begin ah = ua_reg[31:0];  bh = ub_reg[63:32]; end
            3'd3:    begin ah = ua_reg[63:32]; bh = ub_reg[31:0];  end
            3'd4:    begin ah = ua_reg[63:32]; bh = ub_reg[63:32]; end
            default: begin ah = 32'd0;         bh = 32'd0;         end
        endcase
        mult = {32'd0, ah} * {32'd0, bh};
        case (step_reg)
            3'd2:       addend = {65'd0, prod_reg[63:32]};
            3'd3, 3'd4: addend = {33'd0, prod_reg};
            3'd5:       addend = {1'b0, prod_reg, 32'd0};
            default:    addend = 97'd0;
        endcase
        acc_next = acc_reg + addend;
        if (go)
            step_next = 3'd1;
        else if (step_reg == 3'd6)
            step_next = 3'd0;
        else if (step_reg != 3'd0)
            step_next = step_reg + 3'd1;
        else
            step_next = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= 3'd0;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        if (go) begin
            ua_reg  <= mag64(a);
            ub_reg  <= mag64(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= 97'd0;
        end else begin
            acc_reg <= acc_next;
        end
        prod_reg <= mult;
    end

    assign m    = (acc_reg[96:63] != 34'd0) ? WMAX[62:0] : acc_reg[62:0];
    assign res  = neg_reg ? (~{1'b0, m} + 64'd1) : {1'b0, m};
    assign done = (step_reg == 3'd6);

endmodule

>>> rtl/core/lslf_div.sv
// Q32.32 saturating divide, restoring, one quotient bit per cycle.
module lslf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] p,
    output logic        done,
    output logic [63:0] res
);
    import lslf_pkg::*;

    logic        run_reg, done_reg;
    logic [6:0]  cnt_reg;
    logic [95:0] dvd_reg, q_reg;
    logic [63:0] rem_reg, up_reg;
    logic        neg_reg;
    logic [64:0] sh, diff;
    logic        ge;
    logic [62:0] m;

    assign sh   = {rem_reg, dvd_reg[95]};
    assign diff = sh - {1'b0, up_reg};
    assign ge   = (sh >= {1'b0, up_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= run_reg && (cnt_reg == 7'd0);
            if (go) begin
                run_reg <= 1'b1;
                cnt_reg <= DIV_LAST_STEP;
            end else if (run_reg) begin
                if (cnt_reg == 7'd0)
                    run_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go) begin
            dvd_reg <= {mag64(a), 32'd0};
            up_reg  <= mag64(p);
            rem_reg <= 64'd0;
            neg_reg <= a[63] ^ p[63];
        end else if (run_reg) begin
            rem_reg <= ge ? diff[63:0] : sh[63:0];
            q_reg   <= {q_reg[94:0], ge};
            dvd_reg <= {dvd_reg[94:0], 1'b0};
        end
    end

    assign m    = (q_reg[95:63] != 33'd0) ? WMAX[62:0] : q_reg[62:0];
    assign res  = neg_reg ? (~{1'b0, m} + 64'd1) : {1'b0, m};
    assign done = done_reg;

endmodule

>>> rtl/core/lslf_dp.sv
// Datapath: sum accumulation, work matrix, arithmetic units, result register.
module lslf_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  lslf_pkg::sample_t sample,
    input  lslf_pkg::cmd_t    cmd,
    input  logic [15:0]       min_pivot,
    output lslf_pkg::status_t status,
    output logic              result_strobe,
    output lslf_pkg::coef_t   result
);
    import lslf_pkg::*;

    logic signed [15:0] t [NUM_TERMS];
    logic signed [31:0] gprod_reg [GRAM_DEPTH];
    logic signed [31:0] xprod_reg [NUM_TERMS];
    logic               prod_valid_reg;
    logic [63:0]        gram_reg [GRAM_DEPTH];
    logic [63:0]        cross_reg [NUM_TERMS];

    logic [63:0] wm_mem [WM_DEPTH];
    logic [63:0] rd0_reg, rd1_reg;
    logic [63:0] p_reg, f_reg;
    logic [63:0] pv_max_reg;
    logic [1:0]  pv_row_reg;
    logic [63:0] load_sum, wdata, rd0_mag;
    logic [63:0] div_res, mul_res;
    logic        div_done, mul_done;
    logic        strobe_reg;
    coef_t       result_reg;

    assign t[0] = sample.term_0;
    assign t[1] = sample.term_1;
    assign t[2] = sample.term_2;
    assign t[3] = sample.term_3;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (cmd.accum) begin
            for (int i = 0; i < NUM_TERMS; i++) begin
                for (int j = 0; j <= i; j++)
                    gprod_reg[gram_idx(2'(i), 2'(j))] <= t[i] * t[j];
                xprod_reg[i] <= t[i] * sample.target;
            end
        end
    end

    // stage 2: 64-bit sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prod_valid_reg <= 1'b0;
            for (int g = 0; g < GRAM_DEPTH; g++)
                gram_reg[g] <= 64'd0;
            for (int i = 0; i < NUM_TERMS; i++)
                cross_reg[i] <= 64'd0;
        end else begin
            prod_valid_reg <= cmd.accum;
            if (cmd.clear_sums) begin
                for (int g = 0; g < GRAM_DEPTH; g++)
                    gram_reg[g] <= 64'd0;
                for (int i = 0; i < NUM_TERMS; i++)
                    cross_reg[i] <= 64'd0;
            end else if (prod_valid_reg) begin
                for (int g = 0; g < GRAM_DEPTH; g++)
                    gram_reg[g] <= gram_reg[g] + {{32{gprod_reg[g][31]}}, gprod_reg[g]};
                for (int i = 0; i < NUM_TERMS; i++)
                    cross_reg[i] <= cross_reg[i] + {{32{xprod_reg[i][31]}}, xprod_reg[i]};
            end
        end
    end

    assign load_sum = cmd.load_cross ? cross_reg[cmd.row]
                                     : gram_reg[gram_idx(cmd.row, cmd.col[1:0])];

    always_comb
    begin
        case (cmd.wr_sel)
            WR_LOAD: wdata = to_q32(load_sum);
            WR_RD0:  wdata = rd0_reg;
            WR_RD1:  wdata = rd1_reg;
            WR_DIV:  wdata = div_res;
            WR_SUB:  wdata = qsub(rd1_reg, mul_res);
            WR_ONE:  wdata = Q32_ONE;
            WR_ZERO: wdata = 64'd0;
            default: wdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            wm_mem[cmd.wr_addr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd0_en)
            rd0_reg <= wm_mem[cmd.rd0_addr];
        if (cmd.rd1_en)
            rd1_reg <= wm_mem[cmd.rd1_addr];
    end

    assign rd0_mag = mag64(rd0_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.p_ld)
            p_reg <= rd0_reg;
        if (cmd.f_ld)
            f_reg <= rd0_reg;
        if (cmd.pv_clr) begin
            pv_max_reg <= 64'd0;
            pv_row_reg <= cmd.row;
        end else if (cmd.pv_upd && (rd0_mag > pv_max_reg)) begin
            pv_max_reg <= rd0_mag;
            pv_row_reg <= cmd.row;
        end
    end

    lslf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .a     (rd0_reg),
        .p     (p_reg),
        .done  (div_done),
        .res   (div_res)
    );

    lslf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (rd0_reg),
        .b     (f_reg),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign status.pv_ok    = (pv_max_reg != 64'd0) &&
                             (pv_max_reg >= {32'd0, min_pivot, 16'd0});
    assign status.pv_row   = pv_row_reg;
    assign status.div_done = div_done;
    assign status.mul_done = mul_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            result_reg.coef_index <= cmd.row;
            result_reg.coef_value <= cmd.emit_sing ? 32'd0 : to_q16(rd0_reg);
            result_reg.coef_last  <= cmd.emit_last;
            result_reg.singular   <= cmd.emit_sing;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

>>> rtl/core/lslf_ctrl.sv
`include "least_squares_linear_fit_defines.svh"

// Sequencer for accumulation, Gauss-Jordan solve and result output.
module lslf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_sample,
    input  logic [2:0]        terms_used,
    input  lslf_pkg::status_t status,
    output logic              busy,
    output lslf_pkg::cmd_t    cmd
);
    import lslf_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] c_reg, c_next;
    logic [1:0] r_reg, r_next;
    logic [2:0] k_reg, k_next;
    logic       back_reg, back_next;
    logic [2:0] n;
    logic [2:0] c_ext, r_ext;
    logic       col_end, row_more;

    // 0 counts as 1, above the term count as the term count
    assign n = (terms_used == 3'd0) ? 3'd1 :
               (terms_used > 3'(NUM_TERMS)) ? 3'(NUM_TERMS) : terms_used;
    assign c_ext = {1'b0, c_reg};
    assign r_ext = {1'b0, r_reg};
    assign row_more = back_reg ? (r_ext + 3'd1 < c_ext) : (r_ext + 3'd1 < n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            c_reg     <= 2'd0;
            r_reg     <= 2'd0;
            k_reg     <= 3'd0;
            back_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            c_reg     <= c_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
            back_reg  <= back_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        back_next  = back_reg;
        col_end    = 1'b0;
        case (state_reg)
            S_IDLE:
                if (start && last_sample)
                    state_next = S_DRAIN;
            S_DRAIN:
            begin
                r_next     = 2'd0;
                k_next     = 3'd0;
                state_next = S_LOAD;
            end
            S_LOAD:
                if (k_reg == n) begin
                    k_next = 3'd0;
                    if (r_ext == n - 3'd1) begin
                        c_next     = 2'd0;
                        r_next     = 2'd0;
                        back_next  = 1'b0;
                        state_next = S_PV_RD;
                    end else begin
                        r_next = r_reg + 2'd1;
                    end
                end else begin
                    k_next = k_reg + 3'd1;
                end
            S_PV_RD:
                state_next = S_PV_CMP;
            S_PV_CMP:
                if (r_ext == n - 3'd1)
                    state_next = S_PV_CHK;
                else begin
                    r_next     = r_reg + 2'd1;
                    state_next = S_PV_RD;
                end
            S_PV_CHK:
                if (!status.pv_ok)
                    state_next = S_SING;
                else if (status.pv_row != c_reg) begin
                    k_next     = 3'd0;
                    state_next = S_SW_RD;
                end else begin
                    state_next = S_P_RD;
                end
            S_SW_RD:
                state_next = S_SW_W1;
            S_SW_W1:
                state_next = S_SW_W2;
            S_SW_W2:
                if (k_reg == n)
                    state_next = S_P_RD;
                else begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_SW_RD;
                end
            S_P_RD:
                state_next = S_P_LD;
            S_P_LD:
            begin
                k_next     = c_ext + 3'd1;
                state_next = S_DV_RD;
            end
            S_DV_RD:
                state_next = S_DV_GO;
            S_DV_GO:
                state_next = S_DV_WT;
            S_DV_WT:
                if (status.div_done) begin
                    if (k_reg == n)
                        state_next = S_DV_ONE;
                    else begin
                        k_next     = k_reg + 3'd1;
                        state_next = S_DV_RD;
                    end
                end
            S_DV_ONE:
                if (c_ext + 3'd1 < n) begin
                    r_next     = c_reg + 2'd1;
                    state_next = S_F_RD;
                end else begin
                    col_end = 1'b1;
                end
            S_F_RD:
                state_next = S_F_LD;
            S_F_LD:
            begin
                k_next     = c_ext + 3'd1;
                state_next = S_EL_RD;
            end
            S_EL_RD:
                state_next = S_EL_GO;
            S_EL_GO:
                state_next = S_EL_WT;
            S_EL_WT:
                if (status.mul_done) begin
                    if (k_reg == n)
                        state_next = S_EL_ZERO;
                    else begin
                        k_next     = k_reg + 3'd1;
                        state_next = S_EL_RD;
                    end
                end
            S_EL_ZERO:
                if (row_more) begin
                    r_next     = r_reg + 2'd1;
                    state_next = S_F_RD;
                end else begin
                    col_end = 1'b1;
                end
            S_O_RD:
                state_next = S_O_EM;
            S_O_EM:
                if (r_ext == n - 3'd1)
                    state_next = S_DONE;
                else begin
                    r_next     = r_reg + 2'd1;
                    state_next = S_O_RD;
                end
            S_SING:
                state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase

        // column finished: next forward pivot, start of back pass, or output
        if (col_end) begin
            r_next = 2'd0;
            if (c_ext == n - 3'd1) begin
                if (back_reg || (n == 3'd1))
                    state_next = S_O_RD;
                else begin
                    back_next  = 1'b1;
                    c_next     = 2'd1;
                    state_next = S_F_RD;
                end
            end else begin
                c_next = c_reg + 2'd1;
                if (back_reg)
                    state_next = S_F_RD;
                else begin
                    r_next     = c_reg + 2'd1;
                    state_next = S_PV_RD;
                end
            end
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.wr_sel     = WR_ZERO;
        cmd.row        = r_reg;
        cmd.col        = k_reg;
        cmd.load_cross = (k_reg == n);
        cmd.accum      = start && (state_reg == S_IDLE);
        busy           = (state_reg != S_IDLE);
        case (state_reg)
            S_LOAD:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = {r_reg, k_reg};
                cmd.wr_sel  = WR_LOAD;
            end
            S_PV_RD:
            begin
                cmd.rd0_en   = 1'b1;
                cmd.rd0_addr = {r_reg, c_ext};
                cmd.pv_clr   = (r_reg == c_reg);
            end
            S_PV_CMP:
                cmd.pv_upd = 1'b1;
            S_SW_RD:
            begin
                cmd.rd0_en   = 1'b1;
                cmd.rd0_addr = {c_reg, k_reg};
                cmd.rd1_en   = 1'b1;
                cmd.rd1_addr = {status.pv_row, k_reg};
            end
            S_SW_W1:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = {c_reg, k_reg};
                cmd.wr_sel  = WR_RD1;
            end
            S_SW_W2:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = {status.pv_row, k_reg};
                cmd.wr_sel  = WR_RD0;
            end
            S_P_RD:
            begin
                cmd.rd0_en   = 1'b1;
                cmd.rd0_addr = {c_reg, c_ext};
            end
            S_P_LD:
                cmd.p_ld = 1'b1;
            S_DV_RD:
            begin
                cmd.rd0_en   = 1'b1;
                cmd.rd0_addr = {c_reg, k_reg};
            end
            S_DV_GO:
                cmd.div_go = 1'b1;
            S_DV_WT:
            begin
                cmd.wr_en   = status.div_done;
                cmd.wr_addr = {c_reg, k_reg};
                cmd.wr_sel  = WR_DIV;
            end
            S_DV_ONE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = {c_reg, c_ext};
                cmd.wr_sel  = WR_ONE;
            end
            S_F_RD:
            begin
                cmd.rd0_en   = 1'b1;
                cmd.rd0_addr = {r_reg, c_ext};
            end
            S_F_LD:
                cmd.f_ld = 1'b1;
            S_EL_RD:
            begin
                cmd.rd0_en   = 1'b1;
                cmd.rd0_addr = {c_reg, k_reg};
                cmd.rd1_en   = 1'b1;
                cmd.rd1_addr = {r_reg, k_reg};
            end
            S_EL_GO:
                cmd.mul_go = 1'b1;
            S_EL_WT:
            begin
                cmd.wr_en   = status.mul_done;
                cmd.wr_addr = {r_reg, k_reg};
                cmd.wr_sel  = WR_SUB;
            end
            S_EL_ZERO:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = {r_reg, c_ext};
                cmd.wr_sel  = WR_ZERO;
            end
            S_O_RD:
            begin
                cmd.rd0_en   = 1'b1;
                cmd.rd0_addr = {r_reg, n};
            end
            S_O_EM:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = (r_ext == n - 3'd1);
            end
            S_SING:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.emit_sing = 1'b1;
                cmd.row       = 2'd0;
            end
            S_DONE:
                cmd.clear_sums = 1'b1;
            default:
                cmd.accum = cmd.accum;
        endcase
    end

    `LSLF_ASSERT(a_accum_idle, cmd.accum |-> (state_reg == S_IDLE))
    `LSLF_ASSERT(a_div_wait, (state_reg == S_DV_WT) && !status.div_done |=> (state_reg == S_DV_WT))
    `LSLF_ASSERT(a_last_done, cmd.emit && cmd.emit_last |=> (state_reg == S_DONE))
    `LSLF_ASSERT_MSG(a_sing_path, (state_reg == S_PV_CHK) && !status.pv_ok |=> (state_reg == S_SING), "small pivot not flagged")

endmodule
